>>> src/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// Depends on nothing; the including module supplies clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition must never be true outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

>>> src/frd_pkg.sv
// Types, record codes and field widths for the flash record deframer.
// Depends on nothing; used by flash_record_deframer_core.
package frd_pkg;

   localparam logic [31:0] START_BIT      = 32'h8000_0000;
   localparam logic [31:0] ERASED_WORD    = 32'hffff_ffff;
   localparam int          TYPE_LSB       = 26;
   localparam logic [4:0]  RT_MASK        = 5'h1f;
   localparam logic [4:0]  TYPE_UPD_HDR   = 5'h0c;
   localparam logic [4:0]  TYPE_UPD_CHUNK = 5'h0d;
   localparam logic [4:0]  TYPE_UPD_EXEC  = 5'h0e;

   localparam int HDR_BITS  = 20 + 32 + 14 + 14;
   localparam int EXEC_BITS = 20 + 32;

   typedef enum logic [1:0] {
      KIND_HDR   = 2'd0,
      KIND_CHUNK = 2'd1,
      KIND_EXEC  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_STEP
   } state_type;

   typedef enum logic [2:0] {
      F_SEQ,
      F_VER,
      F_START,
      F_END,
      F_ADDR,
      F_BYTE
   } field_type;

   function automatic logic [5:0] field_bits(field_type f);
      logic [5:0] b;
      unique case (f)
         F_SEQ:   b = 6'd20;
         F_VER:   b = 6'd32;
         F_START: b = 6'd14;
         F_END:   b = 6'd14;
         F_ADDR:  b = 6'd13;
         F_BYTE:  b = 6'd8;
         default: b = 6'd8;
      endcase
      return b;
   endfunction

endpackage

>>> src/frd_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module frd_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 40
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/flash_record_deframer_core.sv
// Flash record deframer top level: record buffer, bit-field sequencer, result register.
// Depends on frd_pkg, frd_ram and assert_macros.svh.
// Stalls: a word that closes no deliverable record is taken without stalling. A closing word
// then holds req_stall while the sequencer steps through each field and fetches each buffered
// word it crosses; rsp_stall can lengthen the stall.
// Reset: synchronous, no open record, enable mask all ones, buffer contents undefined.
`include "assert_macros.svh"

module flash_record_deframer_core #(
   parameter int BUFFER_WORDS = 40,
   parameter int CHUNK_BYTES  = 64,
   parameter int CHUNK_SHIFT  = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [2:0]            csr_wdata,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [31:0]           req_flash_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_kind,
   output logic [19:0]           rsp_sequence_res,
   output logic [31:0]           rsp_version,
   output logic [19:0]           rsp_start_addr,
   output logic [19:0]           rsp_end_addr,
   output logic [18:0]           rsp_chunk_addr,
   output logic [5:0]            rsp_byte_index,
   output logic [7:0]            rsp_data_byte,
   output logic                  rsp_last
);
   import frd_pkg::*;

   localparam int ADDR_W     = $clog2(BUFFER_WORDS);
   localparam int FILL_W     = $clog2(BUFFER_WORDS + 1);
   localparam int CHUNK_BITS = 20 + 13 + 8 * CHUNK_BYTES;
   localparam int HDR_WORDS  = (HDR_BITS - TYPE_LSB + 30) / 31 + 1;
   localparam int EXEC_WORDS = (EXEC_BITS - TYPE_LSB + 30) / 31 + 1;
   localparam int DATA_WORDS = (CHUNK_BITS - TYPE_LSB + 30) / 31 + 1;

   state_type          state_ff, state_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [30:0]        first_ff, first_in;
   logic [2:0]         mask_ff, mask_in;
   logic [4:0]         rtype_ff, rtype_in;
   logic [30:0]        word_ff, word_in;
   logic [4:0]         left_ff, left_in;
   logic [ADDR_W-1:0]  pos_ff, pos_in;
   logic [5:0]         need_ff, need_in;
   logic [4:0]         ins_ff, ins_in;
   logic [31:0]        acc_ff, acc_in;
   field_type          field_ff, field_in;
   logic [5:0]         bcnt_ff, bcnt_in;
   logic [19:0]        seq_ff, seq_in;
   logic [31:0]        ver_ff, ver_in;
   logic [19:0]        start_ff, start_in;
   logic [18:0]        ca_ff, ca_in;

   logic               ov_ff, ov_in;
   kind_type           okind_ff, okind_in;
   logic [19:0]        oseq_ff, oseq_in;
   logic [31:0]        over_ff, over_in;
   logic [19:0]        osa_ff, osa_in;
   logic [19:0]        oea_ff, oea_in;
   logic [18:0]        oca_ff, oca_in;
   logic [5:0]         obi_ff, obi_in;
   logic [7:0]         odb_ff, odb_in;
   logic               olast_ff, olast_in;

   logic               ram_wr_en;
   logic               ram_rd_en;
   logic [ADDR_W-1:0]  ram_rd_addr;
   logic [30:0]        ram_rd_data;

   logic               accept;
   logic               out_free;
   logic               take_long;
   logic [4:0]         nl;
   logic [31:0]        mask_left;
   logic [31:0]        mask_need;
   logic [31:0]        piece;
   logic [31:0]        val;
   logic [4:0]         ty;
   logic               go;
   logic               emits;
   logic               last_byte;

   frd_ram #(
      .WIDTH (31),
      .DEPTH (BUFFER_WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (fill_ff[ADDR_W-1:0]),
      .wr_data (req_flash_word[30:0]),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !ov_ff || !rsp_stall;

   // shared field extraction unit
   assign take_long = need_ff > {1'b0, left_ff};
   assign nl        = left_ff - need_ff[4:0];
   assign mask_left = (32'd1 << left_ff) - 32'd1;
   assign mask_need = 32'((33'd1 << need_ff) - 33'd1);
   assign piece     = take_long ? ({1'b0, word_ff} & mask_left)
                                : (({1'b0, word_ff} >> nl) & mask_need);
   assign val       = acc_ff | (piece << ins_ff);

   assign ty = first_ff[30:26] & RT_MASK;
   assign go = (fill_ff != '0) &&
               (((ty == TYPE_UPD_HDR) && mask_ff[0] && (fill_ff >= FILL_W'(HDR_WORDS))) ||
                ((ty == TYPE_UPD_CHUNK) && mask_ff[1] && (fill_ff >= FILL_W'(DATA_WORDS))) ||
                ((ty == TYPE_UPD_EXEC) && mask_ff[2] && (fill_ff >= FILL_W'(EXEC_WORDS))));

   assign emits = (field_ff == F_END) || (field_ff == F_BYTE) ||
                  ((field_ff == F_VER) && (rtype_ff == TYPE_UPD_EXEC));
   assign last_byte = (bcnt_ff == 6'(CHUNK_BYTES - 1));

   assign ram_wr_en = accept && !req_flash_word[31] && (fill_ff != '0) &&
                      (fill_ff < FILL_W'(BUFFER_WORDS));

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      first_in  = first_ff;
      mask_in   = mask_ff;
      rtype_in  = rtype_ff;
      word_in   = word_ff;
      left_in   = left_ff;
      pos_in    = pos_ff;
      need_in   = need_ff;
      ins_in    = ins_ff;
      acc_in    = acc_ff;
      field_in  = field_ff;
      bcnt_in   = bcnt_ff;
      seq_in    = seq_ff;
      ver_in    = ver_ff;
      start_in  = start_ff;
      ca_in     = ca_ff;
      ov_in     = ov_ff && rsp_stall;
      okind_in  = okind_ff;
      oseq_in   = oseq_ff;
      over_in   = over_ff;
      osa_in    = osa_ff;
      oea_in    = oea_ff;
      oca_in    = oca_ff;
      obi_in    = obi_ff;
      odb_in    = odb_ff;
      olast_in  = olast_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = pos_ff + ADDR_W'(1);

      if (csr_valid && csr_ready) begin
         mask_in = csr_wdata;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_flash_word[31]) begin
                  if (go) begin
                     rtype_in = ty;
                     word_in  = first_ff;
                     left_in  = 5'(TYPE_LSB);
                     pos_in   = '0;
                     field_in = F_SEQ;
                     need_in  = field_bits(F_SEQ);
                     acc_in   = '0;
                     ins_in   = '0;
                     state_in = ST_STEP;
                  end
                  first_in = req_flash_word[30:0];
                  fill_in  = (req_flash_word == ERASED_WORD) ? '0 : FILL_W'(1);
               end else if (ram_wr_en) begin
                  fill_in = fill_ff + FILL_W'(1);
               end
            end
         end
         ST_FETCH: begin
            word_in  = ram_rd_data;
            state_in = ST_STEP;
         end
         ST_STEP: begin
            if (take_long) begin
               acc_in    = val;
               ins_in    = ins_ff + left_ff;
               need_in   = need_ff - {1'b0, left_ff};
               left_in   = 5'd31;
               pos_in    = pos_ff + ADDR_W'(1);
               ram_rd_en = 1'b1;
               state_in  = ST_FETCH;
            end else if (!emits || out_free) begin
               left_in = nl;
               acc_in  = '0;
               ins_in  = '0;
               unique case (field_ff)
                  F_SEQ: begin
                     seq_in = val[19:0];
                     if (rtype_ff == TYPE_UPD_CHUNK) begin
                        field_in = F_ADDR;
                        need_in  = field_bits(F_ADDR);
                     end else begin
                        field_in = F_VER;
                        need_in  = field_bits(F_VER);
                     end
                  end
                  F_VER: begin
                     ver_in = val;
                     if (rtype_ff == TYPE_UPD_EXEC) begin
                        ov_in    = 1'b1;
                        okind_in = KIND_EXEC;
                        oseq_in  = seq_ff;
                        over_in  = val;
                        osa_in   = '0;
                        oea_in   = '0;
                        oca_in   = '0;
                        obi_in   = '0;
                        odb_in   = '0;
                        olast_in = 1'b1;
                        state_in = ST_IDLE;
                     end else begin
                        field_in = F_START;
                        need_in  = field_bits(F_START);
                     end
                  end
                  F_START: begin
                     start_in = 20'(val[13:0]) << CHUNK_SHIFT;
                     field_in = F_END;
                     need_in  = field_bits(F_END);
                  end
                  F_END: begin
                     ov_in    = 1'b1;
                     okind_in = KIND_HDR;
                     oseq_in  = seq_ff;
                     over_in  = ver_ff;
                     osa_in   = start_ff;
                     oea_in   = 20'(val[13:0]) << CHUNK_SHIFT;
                     oca_in   = '0;
                     obi_in   = '0;
                     odb_in   = '0;
                     olast_in = 1'b1;
                     state_in = ST_IDLE;
                  end
                  F_ADDR: begin
                     ca_in    = 19'(val[12:0]) << CHUNK_SHIFT;
                     bcnt_in  = '0;
                     field_in = F_BYTE;
                     need_in  = field_bits(F_BYTE);
                  end
                  F_BYTE: begin
                     ov_in    = 1'b1;
                     okind_in = KIND_CHUNK;
                     oseq_in  = seq_ff;
                     over_in  = '0;
                     osa_in   = '0;
                     oea_in   = '0;
                     oca_in   = ca_ff;
                     obi_in   = bcnt_ff;
                     odb_in   = val[7:0];
                     olast_in = last_byte;
                     bcnt_in  = bcnt_ff + 6'd1;
                     need_in  = field_bits(F_BYTE);
                     if (last_byte) begin
                        state_in = ST_IDLE;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         mask_ff  <= 3'b111;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         mask_ff  <= mask_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff <= first_in;
      rtype_ff <= rtype_in;
      word_ff  <= word_in;
      left_ff  <= left_in;
      pos_ff   <= pos_in;
      need_ff  <= need_in;
      ins_ff   <= ins_in;
      acc_ff   <= acc_in;
      field_ff <= field_in;
      bcnt_ff  <= bcnt_in;
      seq_ff   <= seq_in;
      ver_ff   <= ver_in;
      start_ff <= start_in;
      ca_ff    <= ca_in;
      okind_ff <= okind_in;
      oseq_ff  <= oseq_in;
      over_ff  <= over_in;
      osa_ff   <= osa_in;
      oea_ff   <= oea_in;
      oca_ff   <= oca_in;
      obi_ff   <= obi_in;
      odb_ff   <= odb_in;
      olast_ff <= olast_in;
   end

   assign rsp_valid        = ov_ff;
   assign rsp_kind         = okind_ff;
   assign rsp_sequence_res = oseq_ff;
   assign rsp_version      = over_ff;
   assign rsp_start_addr   = osa_ff;
   assign rsp_end_addr     = oea_ff;
   assign rsp_chunk_addr   = oca_ff;
   assign rsp_byte_index   = obi_ff;
   assign rsp_data_byte    = odb_ff;
   assign rsp_last         = olast_ff;

   `ASSERT_CLK(a_fill_bound, fill_ff <= FILL_W'(BUFFER_WORDS), "fill count past buffer depth")
   `ASSERT_CLK(a_chunk_last,
               (rsp_valid && (rsp_kind == KIND_CHUNK) && rsp_last) |->
               (rsp_byte_index == 6'(CHUNK_BYTES - 1)),
               "chunk last flag on wrong byte")
   `ASSERT_CLK(a_rsp_from_step,
               (ov_ff && !$past(ov_ff && rsp_stall) && !$past(reset)) |->
               ($past(state_ff) == ST_STEP),
               "result loaded outside field step")
   `ASSERT_NEVER(a_append_while_busy, ram_wr_en && (state_ff != ST_IDLE), "buffer written during record parse")

endmodule
